// ===== rtl/epmc_pkg.sv =====
// Shared constants, register codes and queue item type for the pattern match counter.
`default_nettype none

package epmc_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int LEN_REG_W = 6;
	localparam int WORD_W    = 64;
	localparam int PAT_WORDS = 4;
	localparam int PAT_BYTES = 32;
	localparam int PB_W      = $clog2(PAT_BYTES);
	localparam int CFG_IDX_W = 3;
	localparam int MIN_LEN   = 2;

	localparam logic [LEN_REG_W-1:0] LEN_RESET = 6'd2;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEN   = 3'd0,
		REG_WORD0 = 3'd1,
		REG_WORD1 = 3'd2,
		REG_WORD2 = 3'd3,
		REG_WORD3 = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic hit;
		logic last;
	} epmc_item_t;

endpackage

`default_nettype wire

// ===== rtl/epmc_cfg.sv =====
// Configuration registers and the sweep that lines the pattern up by byte age.
`default_nettype none

module epmc_cfg import epmc_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > LEN_REG_W) ?
		$clog2(MAX_PATTERN + 1) : LEN_REG_W,
	localparam int IDX_W = $clog2(MAX_PATTERN)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [WORD_W-1:0]      cfg_data,
	output logic [7:0]                  align_pat [MAX_PATTERN],
	output logic [MAX_PATTERN-1:0]      align_mask,
	output logic [LEN_W-1:0]            eff_len,
	output logic                        busy
);

	logic [LEN_REG_W-1:0] len_q;
	logic [WORD_W-1:0]    word_q [PAT_WORDS];
	logic                 busy_q;
	logic [IDX_W-1:0]     idx_q;
	logic [7:0]           align_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] mask_q;

	logic [7:0]       pat_byte [PAT_BYTES];
	logic [LEN_W-1:0] len_ext;
	logic [LEN_W-1:0] idx_ext;
	logic [LEN_W-1:0] diff;
	logic             in_len;
	logic [7:0]       sel_byte;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			for (int w = 0; w < PAT_WORDS; w++) begin
				word_q[w] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_LEN:   len_q     <= cfg_data[LEN_REG_W-1:0];
				REG_WORD0: word_q[0] <= cfg_data;
				REG_WORD1: word_q[1] <= cfg_data;
				REG_WORD2: word_q[2] <= cfg_data;
				REG_WORD3: word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the programmed length into the supported range
	always_comb begin
		len_ext = LEN_W'(len_q);
		if (len_ext < LEN_W'(MIN_LEN)) begin
			eff_len = LEN_W'(MIN_LEN);
		end else if (len_ext > LEN_W'(MAX_PATTERN)) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end else begin
			eff_len = len_ext;
		end
	end

	always_comb begin
		for (int b = 0; b < PAT_BYTES; b++) begin
			pat_byte[b] = word_q[b >> 3][(b & 7) * 8 +: 8];
		end
	end

	// entry idx holds the pattern byte expected at age idx: byte eff_len-1-idx
	always_comb begin
		idx_ext  = LEN_W'(idx_q);
		in_len   = idx_ext < eff_len;
		diff     = eff_len - LEN_W'(1) - idx_ext;
		sel_byte = (diff < LEN_W'(PAT_BYTES)) ? pat_byte[diff[PB_W-1:0]] : 8'd0;
	end

	// a sweep runs after reset and after every register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (cfg_valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == IDX_W'(MAX_PATTERN - 1)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			align_q[idx_q] <= in_len ? sel_byte : 8'd0;
			mask_q[idx_q]  <= in_len;
		end
	end

	assign align_pat  = align_q;
	assign align_mask = mask_q;
	assign busy       = busy_q;

endmodule

`default_nettype wire

// ===== rtl/epmc_front.sv =====
// Front end: input transfer, byte window and parallel window compare.
`default_nettype none

module epmc_front import epmc_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > LEN_REG_W) ?
		$clog2(MAX_PATTERN + 1) : LEN_REG_W,
	localparam int SEEN_W = $clog2(MAX_PATTERN + 1),
	localparam int CMP_W  = LEN_W + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             text_byte,
	input  wire logic                   last_byte,
	input  wire logic [7:0]             align_pat [MAX_PATTERN],
	input  wire logic [MAX_PATTERN-1:0] align_mask,
	input  wire logic [LEN_W-1:0]       eff_len,
	input  wire logic                   cfg_busy,
	input  wire logic                   q_full,
	output logic                        push,
	output epmc_item_t                  push_item
);

	logic [7:0]            win_q [MAX_PATTERN-1];
	logic [SEEN_W-1:0]     seen_q;
	logic [7:0]            age_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;
	logic                  enough;

	assign in_ready = !cfg_busy && !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		age_byte[0] = text_byte;
		for (int a = 1; a < MAX_PATTERN; a++) begin
			age_byte[a] = win_q[a-1];
		end
		for (int a = 0; a < MAX_PATTERN; a++) begin
			eq[a] = (age_byte[a] == align_pat[a]) || !align_mask[a];
		end
	end

	// every compared age must belong to the current text
	assign enough = (CMP_W'(seen_q) + CMP_W'(1)) >= CMP_W'(eff_len);

	assign push_item.hit  = enough && (&eq);
	assign push_item.last = last_byte;

	// bytes older than the text start are masked by seen_q, so no clear needed
	always_ff @(posedge clk) begin
		if (push) begin
			win_q[0] <= text_byte;
			for (int k = 1; k < MAX_PATTERN - 1; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push) begin
			if (last_byte) begin
				seen_q <= '0;
			end else if (seen_q != SEEN_W'(MAX_PATTERN)) begin
				seen_q <= seen_q + SEEN_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/epmc_queue.sv =====
// Short queue of classified bytes between front and back end.
`default_nettype none

module epmc_queue import epmc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  epmc_item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output epmc_item_t pop_item,
	output logic       not_empty
);

	epmc_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/epmc_back.sv =====
// Back end: saturating occurrence count and the output register.
`default_nettype none

module epmc_back import epmc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  epmc_item_t                  q_item,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        match_here,
	output logic [COUNT_WIDTH-1:0]      match_count,
	output logic                        text_done
);

	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic                   out_valid_q;
	logic                   match_here_q;
	logic [COUNT_WIDTH-1:0] match_count_q;
	logic                   text_done_q;

	assign pop = q_valid && (!out_valid_q || out_ready);

	assign cnt_next = (q_item.hit && (total_q != '1)) ? total_q + COUNT_WIDTH'(1) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			total_q     <= q_item.last ? '0 : cnt_next;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			match_here_q  <= q_item.hit;
			match_count_q <= cnt_next;
			text_done_q   <= q_item.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_here  = match_here_q;
	assign match_count = match_count_q;
	assign text_done   = text_done_q;

endmodule

`default_nettype wire

// ===== rtl/exact_pattern_match_counter.sv =====
// Top level: counts occurrences of a programmed byte pattern in a byte stream.
//
// Input channel (in_valid/in_ready) carries one text byte per transfer with
// last_byte marking the end of a text. Output channel (out_valid/out_ready)
// returns one result per byte: match_here, the saturating match_count of the
// current text, and text_done. The count and window fill restart after a
// byte with last_byte set.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// pattern_length (index 0) and the four pattern words (1 to 4); cfg_ready is
// always high and unknown indexes are ignored.
// Throughput: one byte per cycle while in_ready is high; all window compares
// run in parallel. A transferred byte is written into the queue and is popped
// into the output register when it is free; that register presents the result.
// After reset and after every configuration write, the pattern alignment
// sweep steps through all MAX_PATTERN entries, during which in_ready is low.
// When out_ready is low, the output register holds its result and the two
// entry queue keeps taking bytes until full, then in_ready drops.
`default_nettype none

module exact_pattern_match_counter import epmc_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 last_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      match_here,
	output logic [COUNT_WIDTH-1:0]    match_count,
	output logic                      text_done,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > LEN_REG_W) ?
		$clog2(MAX_PATTERN + 1) : LEN_REG_W;

	logic [7:0]             align_pat [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] align_mask;
	logic [LEN_W-1:0]       eff_len;
	logic                   cfg_busy;
	logic                   q_full;
	logic                   push;
	epmc_item_t             push_item;
	logic                   pop;
	epmc_item_t             pop_item;
	logic                   q_not_empty;

	epmc_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.align_pat  (align_pat),
		.align_mask (align_mask),
		.eff_len    (eff_len),
		.busy       (cfg_busy)
	);

	epmc_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.align_pat  (align_pat),
		.align_mask (align_mask),
		.eff_len    (eff_len),
		.cfg_busy   (cfg_busy),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	epmc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.pop_item   (pop_item),
		.not_empty  (q_not_empty)
	);

	epmc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_item      (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match_here  (match_here),
		.match_count (match_count),
		.text_done   (text_done)
	);

endmodule

`default_nettype wire

// ===== rtl/epmc_chk.sv =====
// Port-level checks for the pattern match counter, bound to the top level.
`default_nettype none

module epmc_chk import epmc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   match_here,
	input wire logic [COUNT_WIDTH-1:0] match_count,
	input wire logic                   text_done,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_here) &&
			$stable(match_count) && $stable(text_done))
		else $error("output changed while stalled");

	// a match always leaves a nonzero count, saturation included
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_here |-> match_count != '0)
		else $error("match reported with zero count");

	// a register write starts the alignment sweep, which blocks input
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken right after a register write");

endmodule

bind exact_pattern_match_counter epmc_chk #(.COUNT_WIDTH(COUNT_WIDTH)) u_epmc_chk (.*);

`default_nettype wire

// ===== bench/exact_pattern_match_counter_tb.sv =====
// Self-checking testbench for the exact pattern match counter, with its own scan predictor.
`timescale 1ns / 100ps

module exact_pattern_match_counter_tb;
	import epmc_pkg::*;

	localparam int WIN_DEPTH  = MAX_PATTERN_DEF - 1;
	localparam int CYCLE_CAP  = 400000;
	localparam int ITEM_GOAL  = 1270;
	localparam int CALM_START = 1050;
	localparam logic [31:0] COUNT_TOP = '1;

	typedef struct {
		logic        hit;
		logic [31:0] count;
		logic        done;
	} match_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           text_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 match_here;
	logic [31:0]          match_count;
	logic                 text_done;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	exact_pattern_match_counter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.match_here (match_here),
		.match_count(match_count),
		.text_done  (text_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// predictor copy of the registers and the scan state
	logic [LEN_REG_W-1:0] cfg_len = LEN_RESET;
	logic [WORD_W-1:0]    cfg_words [PAT_WORDS];
	logic [7:0]           window_bytes [WIN_DEPTH];
	int                   text_fill;
	logic [31:0]          match_total;

	match_result_t expected_matches [$];
	match_result_t want;

	int  errors = 0;
	int  items_sent = 0;
	int  cycles = 0;
	bit  calm = 0;
	int  stall_left = 0;

	always #4 clk = ~clk;

	function automatic int active_len();
		int m;
		m = int'(cfg_len);
		if (m < MIN_LEN)
			m = MIN_LEN;
		if (m > MAX_PATTERN_DEF)
			m = MAX_PATTERN_DEF;
		return m;
	endfunction

	function automatic logic [7:0] pattern_at(int idx);
		if (idx >= PAT_BYTES)
			return 8'h00;
		return cfg_words[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	function automatic match_result_t scan_byte(logic [7:0] cur, logic last);
		match_result_t r;
		int m;
		m = active_len();
		r.hit = 1'b0;
		if (text_fill + 1 >= m) begin
			r.hit = (cur == pattern_at(m - 1));
			for (int i = 1; i < m; i++)
				if (window_bytes[i - 1] != pattern_at(m - 1 - i))
					r.hit = 1'b0;
		end
		if (r.hit && match_total != COUNT_TOP)
			match_total = match_total + 1;
		r.count = match_total;
		r.done = last;
		if (last) begin
			foreach (window_bytes[i])
				window_bytes[i] = 8'h00;
			text_fill = 0;
			match_total = '0;
		end else begin
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				window_bytes[i] = window_bytes[i - 1];
			window_bytes[0] = cur;
			if (text_fill < MAX_PATTERN_DEF)
				text_fill++;
		end
		return r;
	endfunction

	initial begin
		foreach (cfg_words[i])
			cfg_words[i] = '0;
		foreach (window_bytes[i])
			window_bytes[i] = 8'h00;
		text_fill = 0;
		match_total = '0;
	end

	// register writes, byte transfers, then result checks, all on the sampled edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LEN:   cfg_len = cfg_data[LEN_REG_W-1:0];
					REG_WORD0: cfg_words[0] = cfg_data;
					REG_WORD1: cfg_words[1] = cfg_data;
					REG_WORD2: cfg_words[2] = cfg_data;
					REG_WORD3: cfg_words[3] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_matches.push_back(scan_byte(text_byte, last_byte));
			if (out_valid && out_ready) begin
				if (expected_matches.size() == 0) begin
					$error("result with nothing expected: match_here=%0d match_count=%0d",
						match_here, match_count);
					errors++;
				end else begin
					want = expected_matches.pop_front();
					if (match_here !== want.hit) begin
						$error("match_here: expected %0d, got %0d", want.hit, match_here);
						errors++;
					end
					if (match_count !== want.count) begin
						$error("match_count: expected %0d, got %0d", want.count, match_count);
						errors++;
					end
					if (text_done !== want.done) begin
						$error("text_done: expected %0d, got %0d", want.done, text_done);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("exact_pattern_match_counter_tb: FAIL");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		text_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_pattern();
		// reset pattern is two zero bytes; overlapping runs of zeros
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_short_length_and_spare_regs();
		write_reg(REG_WORD0, '1);
		write_reg(REG_WORD1, '1);
		write_reg(REG_WORD2, '1);
		write_reg(REG_WORD3, '1);
		for (int k = int'(REG_WORD3) + 1; k < 2 ** CFG_IDX_W; k++)
			write_reg(CFG_IDX_W'(k), '0);
		write_reg(REG_LEN, WORD_W'(1));
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		write_reg(REG_LEN, '0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_pattern_change_mid_text();
		write_reg(REG_WORD0, 64'h0000_0000_0033_2211);
		write_reg(REG_LEN, WORD_W'(3));
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		// window keeps 11 22 across the rewrite
		write_reg(REG_WORD0, 64'h0000_0000_0000_4422);
		write_reg(REG_LEN, WORD_W'(2));
		send_byte(8'h44, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h44, 1'b0);
		send_byte(8'h33, 1'b1);
	endtask

	task automatic program_phase(int phase, output logic [7:0] syms [4], output int nsym);
		logic [7:0]        pat [PAT_BYTES];
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] len_data;
		int                len_code;

		nsym = $urandom_range(1, 4);
		foreach (syms[i])
			syms[i] = 8'($urandom_range(0, 255));
		if (phase == 4) begin
			foreach (syms[i])
				syms[i] = 8'h00;
		end else if (phase == 5) begin
			foreach (syms[i])
				syms[i] = 8'hFF;
		end
		foreach (pat[i])
			pat[i] = syms[$urandom_range(0, nsym - 1)];
		case (phase)
			0: len_code = 0;
			1: len_code = 1;
			2: len_code = 2;
			3: len_code = 32;
			4: len_code = 32;
			5: len_code = 63;
			6: len_code = 33;
			default: len_code = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
				: $urandom_range(2, 6);
		endcase
		for (int w = 0; w < PAT_WORDS; w++) begin
			for (int b = 0; b < 8; b++)
				word[b * 8 +: 8] = pat[w * 8 + b];
			if (phase < 8 || $urandom_range(0, 2) != 0)
				write_reg(cfg_reg_t'(int'(REG_WORD0) + w), word);
		end
		if ($urandom_range(0, 4) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_WORD3) + 1, 2 ** CFG_IDX_W - 1)),
				{$urandom, $urandom});
		// upper bits of the length write are don't-care
		len_data = {$urandom, $urandom};
		len_data[LEN_REG_W-1:0] = LEN_REG_W'(len_code);
		write_reg(REG_LEN, len_data);
	endtask

	task automatic test_random_texts();
		logic [7:0] syms [4];
		logic [7:0] text [$];
		int         nsym;
		int         phase_goal;
		int         tlen;
		int         m;
		bit         close;

		for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
			if (items_sent >= CALM_START)
				calm = 1;
			program_phase(phase, syms, nsym);
			m = active_len();
			phase_goal = items_sent + $urandom_range(40, 90);
			while (items_sent < phase_goal) begin
				tlen = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 100)
					: $urandom_range(1, 30);
				text.delete();
				while (text.size() < tlen) begin
					if ($urandom_range(0, 4) == 0) begin
						for (int i = 0; i < m; i++)
							text.push_back(pattern_at(i));
					end else if ($urandom_range(0, 9) == 0) begin
						text.push_back(8'($urandom_range(0, 255)));
					end else begin
						text.push_back(syms[$urandom_range(0, nsym - 1)]);
					end
				end
				// the phase's final text may stay open into the next setting
				close = (items_sent + text.size() < phase_goal) || ($urandom_range(0, 2) != 0);
				foreach (text[i])
					send_byte(text[i], (i == text.size() - 1) && close);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_pattern();
		test_short_length_and_spare_regs();
		test_pattern_change_mid_text();
		test_random_texts();

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("exact_pattern_match_counter_tb: PASS");
		else
			$display("exact_pattern_match_counter_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/epmc_pkg.sv
rtl/epmc_cfg.sv
rtl/epmc_front.sv
rtl/epmc_queue.sv
rtl/epmc_back.sv
rtl/exact_pattern_match_counter.sv
rtl/epmc_chk.sv
bench/exact_pattern_match_counter_tb.sv
